[rtl/throttle_to_servo_or_dshot_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the throttle to servo / DShot encoder
// Shared concurrent assertion forms; the module in use must have clk and
// arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef THROTTLE_TO_SERVO_OR_DSHOT_ASSERT_SVH
`define THROTTLE_TO_SERVO_OR_DSHOT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define TSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tsd_pkg.sv]
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants of the throttle to servo / DShot encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tsd_pkg;

	// Frame and datapath sizes
	localparam int FRAME_WORDS = 17;
	localparam int LAST_IDX    = FRAME_WORDS - 1;
	localparam int IDX_W       = $clog2(FRAME_WORDS);
	localparam int LEVEL_W     = 10;
	localparam int WORD_W      = 16;
	localparam int TICK_W      = 16;
	localparam int CFG_IDX_W   = 2;

	// Queue between front and back
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

	// Mapping constants
	localparam int LEVEL_MAX   = 1023;
	localparam int SERVO_LOW   = 1000;
	localparam int SERVO_SPAN  = 1000;
	localparam int THR_LOW     = 47;
	localparam int THR_W       = 11;

	// Register reset values
	localparam logic [TICK_W-1:0] ZERO_TICKS_RST = 16'd7;
	localparam logic [TICK_W-1:0] ONE_TICKS_RST  = 16'd15;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OUTPUT_MODE = 2'd0,
		REG_REQ_TELEM   = 2'd1,
		REG_ZERO_TICKS  = 2'd2,
		REG_ONE_TICKS   = 2'd3
	} cfg_reg_t;

	// Back end sequencer states
	typedef enum logic {
		BK_IDLE  = 1'b0,
		BK_FRAME = 1'b1
	} bk_state_t;

	// One classified item: servo pulse width or complete DShot frame
	typedef struct packed {
		logic              dshot;
		logic [WORD_W-1:0] word;
	} fifo_entry_t;

	typedef struct packed {
		logic        valid;
		fifo_entry_t entry;
	} fifo_push_t;

endpackage

`default_nettype wire

[rtl/tsd_front.sv]
// ----------------------------------------------------------------------------
// tsd_front
// Accepts samples, smooths the level and maps it to a servo pulse width or a
// DShot frame over a short pipeline, then pushes the result into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            sample_valid,
	output logic                                 sample_stall,
	input  wire logic [tsd_pkg::LEVEL_W-1:0]     sample,
	input  wire logic                            output_mode,
	input  wire logic                            request_telemetry,
	input  wire logic [tsd_pkg::FIFO_CW-1:0]     fifo_count,
	output tsd_pkg::fifo_push_t                  push
);

	localparam int INFL_W = tsd_pkg::FIFO_CW + 1;
	localparam int PM_W   = 20;
	localparam int P_W    = PM_W + 1;
	localparam int SUM_W  = P_W + 1;

	logic                          sample_take;
	logic [tsd_pkg::LEVEL_W+1:0]   level_sum;
	logic [tsd_pkg::LEVEL_W-1:0]   level_q;
	logic [INFL_W-1:0]             inflight;

	logic                          valid_s1;
	logic [tsd_pkg::LEVEL_W-1:0]   level_s1;
	logic                          dshot_s1;
	logic                          telem_s1;

	logic [PM_W-1:0]               p1000;
	logic [P_W-1:0]                prod;
	logic [SUM_W-1:0]              prod_sum;

	logic                          valid_s2;
	logic [P_W-1:0]                prod_s2;
	logic [tsd_pkg::THR_W-1:0]     qa_s2;
	logic                          dshot_s2;
	logic                          telem_s2;

	logic [SUM_W-1:0]              rem;
	logic [tsd_pkg::THR_W-1:0]     quot;
	logic [tsd_pkg::THR_W-1:0]     throttle;
	logic [11:0]                   payload;
	logic [3:0]                    check;
	logic [tsd_pkg::WORD_W-1:0]    servo_word;

	// Hold off new samples while pipeline plus queue could fill the queue
	always_comb begin
		inflight     = INFL_W'(fifo_count) + INFL_W'(valid_s1) + INFL_W'(valid_s2);
		sample_stall = (inflight >= INFL_W'(tsd_pkg::FIFO_DEPTH));
	end

	assign sample_take = sample_valid && !sample_stall;

	// Smooth: level = (3*level + sample) >> 2
	assign level_sum = {2'b00, level_q} + {1'b0, level_q, 1'b0} + {2'b00, sample};

	// Scale by span (1000 servo, 2000 DShot), first quotient estimate for /1023
	always_comb begin
		p1000    = PM_W'(level_s1) * PM_W'(tsd_pkg::SERVO_SPAN);
		prod     = dshot_s1 ? {p1000, 1'b0} : {1'b0, p1000};
		prod_sum = SUM_W'(prod) + SUM_W'(prod >> 10);
	end

	// Correct the estimate by one, then build servo word or DShot frame
	always_comb begin
		rem        = SUM_W'(prod_s2) - (SUM_W'(qa_s2) << 10) + SUM_W'(qa_s2);
		quot       = qa_s2 + tsd_pkg::THR_W'(rem >= SUM_W'(tsd_pkg::LEVEL_MAX));
		throttle   = quot + tsd_pkg::THR_W'(tsd_pkg::THR_LOW);
		payload    = {throttle, telem_s2};
		check      = payload[3:0] ^ payload[7:4] ^ payload[11:8];
		servo_word = tsd_pkg::WORD_W'(quot) + tsd_pkg::WORD_W'(tsd_pkg::SERVO_LOW);
		push.valid       = valid_s2;
		push.entry.dshot = dshot_s2;
		push.entry.word  = dshot_s2 ? {payload, check} : servo_word;
	end

	// Advance control and smoothed level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= sample_take;
			valid_s2 <= valid_s1;
			if (sample_take) begin
				level_q <= level_sum[tsd_pkg::LEVEL_W+1:2];
			end
		end
	end

	// Advance payload stages
	always_ff @(posedge clk) begin
		if (sample_take) begin
			level_s1 <= level_sum[tsd_pkg::LEVEL_W+1:2];
			dshot_s1 <= output_mode;
			telem_s1 <= request_telemetry;
		end
		if (valid_s1) begin
			prod_s2  <= prod;
			qa_s2    <= prod_sum[10 +: tsd_pkg::THR_W];
			dshot_s2 <= dshot_s1;
			telem_s2 <= telem_s1;
		end
	end

endmodule

`default_nettype wire

[rtl/tsd_fifo.sv]
// ----------------------------------------------------------------------------
// tsd_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "throttle_to_servo_or_dshot_assert.svh"

module tsd_fifo (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tsd_pkg::fifo_push_t          push,
	input  wire logic                         pop,
	output tsd_pkg::fifo_entry_t              head,
	output logic                              fifo_empty,
	output logic [tsd_pkg::FIFO_CW-1:0]       fifo_count
);

	tsd_pkg::fifo_entry_t              entries_q [tsd_pkg::FIFO_DEPTH];
	logic [tsd_pkg::FIFO_AW-1:0]       wr_ptr_q;
	logic [tsd_pkg::FIFO_AW-1:0]       rd_ptr_q;
	logic [tsd_pkg::FIFO_CW-1:0]       count_q;

	assign head       = entries_q[rd_ptr_q];
	assign fifo_empty = (count_q == '0);
	assign fifo_count = count_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + tsd_pkg::FIFO_CW'(push.valid) - tsd_pkg::FIFO_CW'(pop);
		end
	end

	// Store pushed item
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wr_ptr_q] <= push.entry;
		end
	end

	`TSD_ASSERT_NOW(a_no_overflow, push.valid && !pop, count_q < tsd_pkg::FIFO_CW'(tsd_pkg::FIFO_DEPTH), "push into full queue")
	`TSD_ASSERT_NOW(a_no_underflow, pop, count_q != '0, "pop from empty queue")
	`TSD_ASSERT_NEXT(a_count_track, 1'b1, count_q == $past(count_q) + tsd_pkg::FIFO_CW'($past(push.valid)) - tsd_pkg::FIFO_CW'($past(pop)), "queue count out of step")

endmodule

`default_nettype wire

[rtl/tsd_back.sv]
// ----------------------------------------------------------------------------
// tsd_back
// Takes classified items from the queue and emits compare words: one servo
// pulse width, or sixteen DShot bit words MSB first and a closing zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "throttle_to_servo_or_dshot_assert.svh"

module tsd_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tsd_pkg::fifo_entry_t          head,
	input  wire logic                          fifo_empty,
	output logic                               pop,
	input  wire logic [tsd_pkg::TICK_W-1:0]    zero_bit_ticks,
	input  wire logic [tsd_pkg::TICK_W-1:0]    one_bit_ticks,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [tsd_pkg::WORD_W-1:0]         compare_value,
	output logic                               is_last
);

	tsd_pkg::bk_state_t              state_q;
	tsd_pkg::bk_state_t              state_d;
	logic [tsd_pkg::WORD_W-1:0]      frame_q;
	logic [tsd_pkg::WORD_W-1:0]      frame_d;
	logic [tsd_pkg::IDX_W-1:0]       idx_q;
	logic [tsd_pkg::IDX_W-1:0]       idx_d;
	logic                            out_valid_q;
	logic [tsd_pkg::WORD_W-1:0]      compare_value_q;
	logic                            is_last_q;
	logic                            adv;
	logic                            load;
	logic [tsd_pkg::WORD_W-1:0]      load_word;
	logic                            load_last;
	logic                            frame_end;

	// Output register may take a new word when empty or drained
	assign adv       = !out_valid_q || !result_stall;
	assign frame_end = (idx_q == tsd_pkg::IDX_W'(tsd_pkg::LAST_IDX));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsd_pkg::BK_IDLE: begin
				if (adv && !fifo_empty && head.dshot) begin
					state_d = tsd_pkg::BK_FRAME;
				end
			end
			tsd_pkg::BK_FRAME: begin
				if (adv && frame_end) begin
					state_d = tsd_pkg::BK_IDLE;
				end
			end
			default: state_d = tsd_pkg::BK_IDLE;
		endcase
	end

	// Pop, word selection and frame shift
	always_comb begin
		pop       = 1'b0;
		load      = 1'b0;
		load_word = '0;
		load_last = 1'b0;
		frame_d   = frame_q;
		idx_d     = idx_q;
		unique case (state_q)
			tsd_pkg::BK_IDLE: begin
				if (adv && !fifo_empty) begin
					pop  = 1'b1;
					load = 1'b1;
					if (head.dshot) begin
						load_word = head.word[tsd_pkg::WORD_W-1] ? one_bit_ticks : zero_bit_ticks;
						frame_d   = {head.word[tsd_pkg::WORD_W-2:0], 1'b0};
						idx_d     = tsd_pkg::IDX_W'(1);
					end else begin
						load_word = head.word;
						load_last = 1'b1;
					end
				end
			end
			tsd_pkg::BK_FRAME: begin
				if (adv) begin
					load = 1'b1;
					if (frame_end) begin
						load_word = '0;
						load_last = 1'b1;
					end else begin
						load_word = frame_q[tsd_pkg::WORD_W-1] ? one_bit_ticks : zero_bit_ticks;
						frame_d   = {frame_q[tsd_pkg::WORD_W-2:0], 1'b0};
						idx_d     = idx_q + 1'b1;
					end
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// Advance sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsd_pkg::BK_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (adv) begin
				out_valid_q <= load;
			end
		end
	end

	// Hold frame and output word
	always_ff @(posedge clk) begin
		frame_q <= frame_d;
		if (load) begin
			compare_value_q <= load_word;
			is_last_q       <= load_last;
		end
	end

	assign result_valid  = out_valid_q;
	assign compare_value = compare_value_q;
	assign is_last       = is_last_q;

	`TSD_ASSERT_NOW(a_pop_idle, pop, state_q == tsd_pkg::BK_IDLE && !fifo_empty, "pop outside idle or from empty queue")
	`TSD_ASSERT_NOW(a_idx_range, state_q == tsd_pkg::BK_FRAME, idx_q != '0 && idx_q <= tsd_pkg::IDX_W'(tsd_pkg::LAST_IDX), "frame index out of range")
	`TSD_ASSERT_NOW(a_last_idle, out_valid_q && is_last_q, state_q == tsd_pkg::BK_IDLE, "last word shown while frame still running")

endmodule

`default_nettype wire

[rtl/throttle_to_servo_or_dshot.sv]
// ----------------------------------------------------------------------------
// throttle_to_servo_or_dshot
// Turns throttle potentiometer samples into a servo pulse width or a DShot
// frame of compare words.
//
//   Channel   Signals                                  Dir
//   sample    sample_valid, sample_stall, sample[9:0]  in
//   result    result_valid, result_stall,              out
//             compare_value[15:0], is_last
//   config    cfg_wr_en, cfg_index[1:0], cfg_data[15:0] in
//
// Servo mode: one word per sample; a sample may enter every cycle while
// sample_stall is low. DShot mode: 17 words per sample at one word per cycle
// while result_stall is low, paced by the back end serializer.
// Reset clears the smoothed level and the queue, and loads register defaults.
// result_stall holds the output word; sample_stall rises once four items sit
// in the front pipeline and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module throttle_to_servo_or_dshot (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sample_valid,
	output logic                                   sample_stall,
	input  wire logic [tsd_pkg::LEVEL_W-1:0]       sample,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic [tsd_pkg::WORD_W-1:0]             compare_value,
	output logic                                   is_last,
	input  wire logic                              cfg_wr_en,
	input  wire logic [tsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tsd_pkg::TICK_W-1:0]        cfg_data
);

	logic                             output_mode_q;
	logic                             request_telemetry_q;
	logic [tsd_pkg::TICK_W-1:0]       zero_bit_ticks_q;
	logic [tsd_pkg::TICK_W-1:0]       one_bit_ticks_q;
	tsd_pkg::cfg_reg_t                cfg_sel;

	tsd_pkg::fifo_push_t              push;
	tsd_pkg::fifo_entry_t             head;
	logic                             fifo_empty;
	logic [tsd_pkg::FIFO_CW-1:0]      fifo_count;
	logic                             pop;

	assign cfg_sel = tsd_pkg::cfg_reg_t'(cfg_index);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_mode_q       <= 1'b0;
			request_telemetry_q <= 1'b0;
			zero_bit_ticks_q    <= tsd_pkg::ZERO_TICKS_RST;
			one_bit_ticks_q     <= tsd_pkg::ONE_TICKS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_sel)
				tsd_pkg::REG_OUTPUT_MODE: output_mode_q       <= cfg_data[0];
				tsd_pkg::REG_REQ_TELEM:   request_telemetry_q <= cfg_data[0];
				tsd_pkg::REG_ZERO_TICKS:  zero_bit_ticks_q    <= cfg_data;
				tsd_pkg::REG_ONE_TICKS:   one_bit_ticks_q     <= cfg_data;
				default:                  output_mode_q       <= output_mode_q;
			endcase
		end
	end

	tsd_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.sample_valid      (sample_valid),
		.sample_stall      (sample_stall),
		.sample            (sample),
		.output_mode       (output_mode_q),
		.request_telemetry (request_telemetry_q),
		.fifo_count        (fifo_count),
		.push              (push)
	);

	tsd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.head       (head),
		.fifo_empty (fifo_empty),
		.fifo_count (fifo_count)
	);

	tsd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.fifo_empty     (fifo_empty),
		.pop            (pop),
		.zero_bit_ticks (zero_bit_ticks_q),
		.one_bit_ticks  (one_bit_ticks_q),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.compare_value  (compare_value),
		.is_last        (is_last)
	);

endmodule

`default_nettype wire

[tb/throttle_to_servo_or_dshot_tb.sv]
// ----------------------------------------------------------------------------
// throttle_to_servo_or_dshot_tb
// Self-checking bench for the throttle to servo / DShot encoder. Samples go
// in over a valid/stall channel. A predictor keeps its own smoothed level and
// register copy, and it queues the compare words that each accepted sample
// should produce. Every word accepted at the output is checked in order
// against that queue. Both sides idle at random, and one test holds the
// output off long enough to fill the encoder.
// ----------------------------------------------------------------------------
module throttle_to_servo_or_dshot_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tsd_pkg::*;

	localparam logic MODE_SERVO    = 1'b0;
	localparam logic MODE_DSHOT    = 1'b1;
	localparam int   THROTTLE_SPAN = 2000;
	localparam int   IDLE_PCT      = 34;
	localparam int   SETTLE_CYCLES = 8;
	localparam int   REPORT_LIMIT  = 10;
	localparam int   PHASE_ITEMS   = 17;
	localparam int   PHASE_COUNT   = 8;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              last;
	} compare_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 sample_valid;
	logic                 sample_stall;
	logic [LEVEL_W-1:0]   sample;
	logic                 result_valid;
	logic                 result_stall;
	logic [WORD_W-1:0]    compare_value;
	logic                 is_last;
	logic                 cfg_wr_en;
	cfg_reg_t             cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	// Predictor state and register copies
	logic [LEVEL_W-1:0]   smoothed_lvl = '0;
	logic                 mode_sel     = MODE_SERVO;
	logic                 telem_bit    = 1'b0;
	logic [TICK_W-1:0]    zero_ticks   = ZERO_TICKS_RST;
	logic [TICK_W-1:0]    one_ticks    = ONE_TICKS_RST;

	compare_word_t        pending_words[$];
	int                   failures     = 0;
	int                   hold_left    = 0;
	bit                   tx_idle_on   = 1'b1;
	bit                   rx_idle_on   = 1'b1;

	throttle_to_servo_or_dshot i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.compare_value (compare_value),
		.is_last       (is_last),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Smooth the sample, then queue the servo width or the DShot frame words
	function automatic void predict_sample(input logic [LEVEL_W-1:0] value);
		int unsigned   lvl;
		int unsigned   scaled;
		logic [11:0]   payload;
		logic [3:0]    crc;
		logic [15:0]   frame;
		compare_word_t w;
		int            k;
		lvl = (3 * int'(smoothed_lvl) + int'(value)) >> 2;
		smoothed_lvl = lvl[LEVEL_W-1:0];
		if (mode_sel == MODE_SERVO) begin
			scaled = lvl * SERVO_SPAN / LEVEL_MAX + SERVO_LOW;
			w.value = scaled[WORD_W-1:0];
			w.last = 1'b1;
			pending_words.push_back(w);
		end else begin
			scaled = lvl * THROTTLE_SPAN / LEVEL_MAX + THR_LOW;
			payload = {scaled[THR_W-1:0], telem_bit};
			crc = payload[3:0] ^ payload[7:4] ^ payload[11:8];
			frame = {payload, crc};
			for (k = 15; k >= 0; k--) begin
				w.value = frame[k] ? one_ticks : zero_ticks;
				w.last = 1'b0;
				pending_words.push_back(w);
			end
			w.value = '0;
			w.last = 1'b1;
			pending_words.push_back(w);
		end
	endfunction

	task automatic log_failure(input string msg);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Check every accepted output word against the oldest prediction
	always @(posedge clk) begin : check_results
		compare_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_words.size() == 0) begin
				log_failure($sformatf("unexpected word compare_value=%0d is_last=%0b",
					compare_value, is_last));
			end else begin
				want = pending_words.pop_front();
				if (compare_value !== want.value || is_last !== want.last)
					log_failure($sformatf("expected %0d/%0b got %0d/%0b",
						want.value, want.last, compare_value, is_last));
			end
		end
	end

	// Drive the output stall: long hold-off first, else random idling
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Offer one sample, hold it until taken, then predict its words
	task automatic send_sample(input logic [LEVEL_W-1:0] value);
		@(negedge clk);
		while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= value;
		do @(posedge clk); while (sample_stall);
		predict_sample(value);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [TICK_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_OUTPUT_MODE: mode_sel = data[0];
			REG_REQ_TELEM:   telem_bit = data[0];
			REG_ZERO_TICKS:  zero_ticks = data;
			REG_ONE_TICKS:   one_ticks = data;
			default: ;
		endcase
	endtask

	// Drop valid and wait until every predicted word has come out
	task automatic wait_drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [TICK_W-1:0] pick_ticks();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return TICK_W'($urandom_range(65535));
		endcase
	endfunction

	// Servo mode from reset defaults; push the level up toward its ceiling
	task automatic test_servo_extremes();
		int n;
		send_sample('0);
		for (n = 0; n < 6; n++)
			send_sample('1);
		send_sample('0);
		wait_drain();
	endtask

	// DShot frames with default ticks, telemetry on, and extreme tick values
	task automatic test_dshot_frames();
		write_reg(REG_OUTPUT_MODE, {15'd0, MODE_DSHOT});
		send_sample('1);
		send_sample(10'd512);
		wait_drain();
		write_reg(REG_REQ_TELEM, 16'd1);
		write_reg(REG_ZERO_TICKS, 16'd0);
		write_reg(REG_ONE_TICKS, 16'hFFFF);
		send_sample('0);
		send_sample(10'd341);
		wait_drain();
		write_reg(REG_ZERO_TICKS, 16'hFFFF);
		write_reg(REG_ONE_TICKS, 16'd0);
		send_sample('1);
		wait_drain();
	endtask

	// One-bit registers keep only bit 0 of the written data
	task automatic test_register_masking();
		write_reg(REG_OUTPUT_MODE, 16'hFFFF);
		write_reg(REG_REQ_TELEM, 16'hAAAA);
		send_sample(10'h2AA);
		wait_drain();
		write_reg(REG_OUTPUT_MODE, 16'h0002);
		write_reg(REG_REQ_TELEM, 16'h5555);
		send_sample(10'h155);
		wait_drain();
	endtask

	// Hold the output off while samples keep coming, so the input stalls
	task automatic test_queue_backpressure();
		int n;
		write_reg(REG_OUTPUT_MODE, {15'd0, MODE_DSHOT});
		hold_left = 300;
		for (n = 0; n < 8; n++)
			send_sample(LEVEL_W'($urandom_range(1023)));
		wait_drain();
	endtask

	// Random samples over several random register settings
	task automatic test_random_phases();
		int                phase;
		int                n;
		bit                quiet;
		logic              mode_pick;
		logic [TICK_W-1:0] junk;
		logic [LEVEL_W-1:0] value;
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			quiet = (phase == 2);
			mode_pick = quiet ? MODE_DSHOT : logic'($urandom_range(1));
			junk = TICK_W'($urandom);
			write_reg(REG_OUTPUT_MODE, {junk[TICK_W-1:1], mode_pick});
			write_reg(REG_REQ_TELEM, TICK_W'($urandom));
			write_reg(REG_ZERO_TICKS, pick_ticks());
			write_reg(REG_ONE_TICKS, pick_ticks());
			tx_idle_on = !quiet;
			rx_idle_on = !quiet;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(9))
					0: value = '0;
					1: value = '1;
					default: value = LEVEL_W'($urandom_range(1023));
				endcase
				send_sample(value);
			end
			wait_drain();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_OUTPUT_MODE;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_servo_extremes();
		test_dshot_frames();
		test_register_masking();
		test_queue_backpressure();
		test_random_phases();

		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/tsd_pkg.sv
rtl/tsd_front.sv
rtl/tsd_fifo.sv
rtl/tsd_back.sv
rtl/throttle_to_servo_or_dshot.sv
tb/throttle_to_servo_or_dshot_tb.sv
